[rtl/core/tss_pkg.sv]
// ----------------------------------------------------------------------------
// Three-shunt current sensing package
// Shared constants, command codes and the sample plan type.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int SAMPLE_COUNT = 16;

   localparam int HALF_PERIOD_W = 15;
   localparam int DATA_W        = 16;
   localparam int OFFSET_W      = 20;
   localparam int AB_COUNT_W    = 7;
   localparam int C_COUNT_W     = 6;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 15'd5250;

   // Command codes.
   localparam logic [2:0] CMD_DUTY      = 3'd0;
   localparam logic [2:0] CMD_RUN       = 3'd1;
   localparam logic [2:0] CMD_CAL_CLEAR = 3'd2;
   localparam logic [2:0] CMD_CAL_AB    = 3'd3;
   localparam logic [2:0] CMD_CAL_C     = 3'd4;
   localparam logic [2:0] CMD_CAL_DONE  = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_AFTER  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_BEFORE = 2'd2;

   // Phase codes.
   localparam logic [1:0] PHASE_A = 2'd0;
   localparam logic [1:0] PHASE_B = 2'd1;
   localparam logic [1:0] PHASE_C = 2'd2;

   // Sector codes that matter to the decoder.
   localparam logic [2:0] SEC1 = 3'd1;
   localparam logic [2:0] SEC2 = 3'd2;
   localparam logic [2:0] SEC3 = 3'd3;
   localparam logic [2:0] SEC4 = 3'd4;
   localparam logic [2:0] SEC5 = 3'd5;
   localparam logic [2:0] SEC6 = 3'd6;

   typedef struct packed {
      logic [DATA_W-1:0] sample_point;
      logic              falling_edge;
      logic [1:0]        first_phase;
      logic [1:0]        second_phase;
      logic [2:0]        sample_sector;
   } plan_type;

endpackage

[rtl/core/tss_duty_plan.sv]
// ----------------------------------------------------------------------------
// Sample point planner
// Chooses the ADC trigger point, trigger edge and converted phase pair from
// one duty update.
// ----------------------------------------------------------------------------
module tss_duty_plan
   import tss_pkg::*;
(
   input  logic [2:0]               sector,
   input  logic [DATA_W-1:0]        duty_a,
   input  logic [DATA_W-1:0]        duty_b,
   input  logic [DATA_W-1:0]        duty_c,
   input  logic [HALF_PERIOD_W-1:0] half_period,
   input  logic [DATA_W-1:0]        time_after,
   input  logic [DATA_W-1:0]        time_before,
   output plan_type                 plan
);

   logic [DATA_W-1:0] x_duty;
   logic [DATA_W-1:0] y_duty;
   logic [1:0]        pair_first;
   logic [1:0]        pair_second;
   logic              known_sector;
   logic [DATA_W-1:0] half_ext;
   logic [DATA_W-1:0] room;
   logic [DATA_W-1:0] delta;
   logic [DATA_W-1:0] late_point;
   logic [DATA_W-1:0] mirrored;

   always_comb begin
      known_sector = 1'b1;
      x_duty       = duty_a;
      y_duty       = duty_b;
      pair_first   = PHASE_B;
      pair_second  = PHASE_C;
      unique case (sector)
         SEC1: begin
            x_duty = duty_a; y_duty = duty_b;
            pair_first = PHASE_B; pair_second = PHASE_C;
         end
         SEC2: begin
            x_duty = duty_b; y_duty = duty_a;
            pair_first = PHASE_A; pair_second = PHASE_C;
         end
         SEC3: begin
            x_duty = duty_b; y_duty = duty_c;
            pair_first = PHASE_A; pair_second = PHASE_C;
         end
         SEC4: begin
            x_duty = duty_c; y_duty = duty_b;
            pair_first = PHASE_A; pair_second = PHASE_B;
         end
         SEC5: begin
            x_duty = duty_c; y_duty = duty_a;
            pair_first = PHASE_A; pair_second = PHASE_B;
         end
         SEC6: begin
            x_duty = duty_a; y_duty = duty_c;
            pair_first = PHASE_B; pair_second = PHASE_C;
         end
         default: begin
            known_sector = 1'b0;
         end
      endcase
   end

   assign half_ext   = {1'b0, half_period};
   assign room       = half_ext - x_duty;
   assign delta      = x_duty - y_duty;
   assign late_point = x_duty + time_after;
   assign mirrored   = {half_period, 1'b0} - late_point - 16'd1;

   always_comb begin
      plan.sample_point  = '0;
      plan.falling_edge  = 1'b0;
      plan.first_phase   = PHASE_A;
      plan.second_phase  = PHASE_B;
      plan.sample_sector = sector;
      if (known_sector) begin
         if (room > time_after) begin
            // Enough time before the centre: sample A and B just before it.
            plan.sample_sector = SEC4;
            plan.sample_point  = half_ext - 16'd1;
         end else begin
            plan.first_phase  = pair_first;
            plan.second_phase = pair_second;
            if ({1'b0, delta} > {room, 1'b0}) begin
               plan.sample_point = x_duty - time_before;
            end else if (late_point >= half_ext) begin
               // The point falls past the centre, so mirror it onto the down-count.
               plan.falling_edge = 1'b1;
               plan.sample_point = mirrored;
            end else begin
               plan.sample_point = late_point;
            end
         end
      end
   end

endmodule

[rtl/core/three_shunt_current_sensing_unit.sv]
// A request passes from the input register to the result register, where its
// result is valid; an output stall holds it in the input register. Throughput:
// one request per cycle while the output does not stall; each register holds
// one request, and the state is updated as a request enters the result register.
// Synchronous reset clears both valid flags, the offsets, counts, recorded sector
// and currents, and returns the configuration registers to their default values.
// ----------------------------------------------------------------------------
// Three-shunt current sensing unit
// Plans ADC sampling from duty updates, rebuilds phase currents from sample
// pairs and runs the offset calibration.
// ----------------------------------------------------------------------------
module three_shunt_current_sensing_unit
   import tss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_command,
   input  logic [2:0]               req_sector,
   input  logic [DATA_W-1:0]        req_duty_a,
   input  logic [DATA_W-1:0]        req_duty_b,
   input  logic [DATA_W-1:0]        req_duty_c,
   input  logic [DATA_W-1:0]        req_adc_first,
   input  logic [DATA_W-1:0]        req_adc_second,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DATA_W-1:0]        rsp_sample_point,
   output logic                     rsp_falling_edge,
   output logic [1:0]               rsp_first_phase,
   output logic [1:0]               rsp_second_phase,
   output logic signed [DATA_W-1:0] rsp_current_a,
   output logic signed [DATA_W-1:0] rsp_current_b,
   output logic signed [DATA_W-1:0] rsp_current_c,
   output logic [DATA_W-1:0]        rsp_compare_a,
   output logic [DATA_W-1:0]        rsp_compare_b,
   output logic [DATA_W-1:0]        rsp_compare_c,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   localparam int CALC_W = 23;
   localparam logic signed [CALC_W-1:0] SAT_HI = 23'sd32767;
   localparam logic signed [CALC_W-1:0] SAT_LO = -23'sd32767;
   localparam logic [AB_COUNT_W-1:0] AB_LIMIT = AB_COUNT_W'(SAMPLE_COUNT);
   localparam logic [C_COUNT_W-1:0]  C_LIMIT  = C_COUNT_W'(SAMPLE_COUNT / 2);

   function automatic logic signed [DATA_W-1:0] sat_current(
      input logic signed [CALC_W-1:0] v
   );
      logic signed [DATA_W-1:0] r;
      if (v < SAT_LO) begin
         r = SAT_LO[DATA_W-1:0];
      end else if (v > SAT_HI) begin
         r = SAT_HI[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [HALF_PERIOD_W-1:0] half_period_ff;
   logic [DATA_W-1:0]        time_after_ff;
   logic [DATA_W-1:0]        time_before_ff;

   // Input register.
   logic                     s1_valid_ff;
   logic [2:0]               s1_command_ff;
   logic [2:0]               s1_sector_ff;
   logic [DATA_W-1:0]        s1_duty_a_ff;
   logic [DATA_W-1:0]        s1_duty_b_ff;
   logic [DATA_W-1:0]        s1_duty_c_ff;
   logic [DATA_W-1:0]        s1_adc_first_ff;
   logic [DATA_W-1:0]        s1_adc_second_ff;

   // Block state.
   logic [2:0]               sample_sector_ff, sample_sector_in;
   logic [OFFSET_W-1:0]      offset_a_ff, offset_a_in;
   logic [OFFSET_W-1:0]      offset_b_ff, offset_b_in;
   logic [OFFSET_W-1:0]      offset_c_ff, offset_c_in;
   logic [AB_COUNT_W-1:0]    ab_count_ff, ab_count_in;
   logic [C_COUNT_W-1:0]     c_count_ff, c_count_in;
   logic signed [DATA_W-1:0] last_current_a_ff, last_current_a_in;
   logic signed [DATA_W-1:0] last_current_b_ff, last_current_b_in;

   // Result register.
   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        sample_point_ff, sample_point_in;
   logic                     falling_edge_ff, falling_edge_in;
   logic [1:0]               first_phase_ff, first_phase_in;
   logic [1:0]               second_phase_ff, second_phase_in;
   logic [DATA_W-1:0]        compare_a_ff, compare_a_in;
   logic [DATA_W-1:0]        compare_b_ff, compare_b_in;
   logic [DATA_W-1:0]        compare_c_ff, compare_c_in;

   logic                     req_accept;
   logic                     result_load;
   plan_type                 plan;

   // Reconstruction terms.
   logic signed [CALC_W-1:0] off_a_s;
   logic signed [CALC_W-1:0] off_b_s;
   logic signed [CALC_W-1:0] off_c_s;
   logic signed [CALC_W-1:0] twice_first_s;
   logic signed [CALC_W-1:0] twice_second_s;
   logic signed [DATA_W-1:0] ia_direct;
   logic signed [DATA_W-1:0] ib_direct;
   logic signed [DATA_W-1:0] ib_first;
   logic signed [DATA_W-1:0] ia_from_b;
   logic signed [DATA_W-1:0] ib_from_a;
   logic [OFFSET_W:0]        off_a_twice;
   logic [OFFSET_W:0]        off_b_twice;
   logic [OFFSET_W:0]        off_c_twice;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign result_load = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !result_load;
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (result_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff    <= req_command;
         s1_sector_ff     <= req_sector;
         s1_duty_a_ff     <= req_duty_a;
         s1_duty_b_ff     <= req_duty_b;
         s1_duty_c_ff     <= req_duty_c;
         s1_adc_first_ff  <= req_adc_first;
         s1_adc_second_ff <= req_adc_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         time_after_ff  <= '0;
         time_before_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata[HALF_PERIOD_W-1:0];
            CSR_TIME_AFTER:  time_after_ff  <= csr_wdata;
            CSR_TIME_BEFORE: time_before_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sample planning
   // ------------------------------------------------------------------------
   tss_duty_plan u_duty_plan (
      .sector      (s1_sector_ff),
      .duty_a      (s1_duty_a_ff),
      .duty_b      (s1_duty_b_ff),
      .duty_c      (s1_duty_c_ff),
      .half_period (half_period_ff),
      .time_after  (time_after_ff),
      .time_before (time_before_ff),
      .plan        (plan)
   );

   // ------------------------------------------------------------------------
   // Current reconstruction
   // ------------------------------------------------------------------------
   assign off_a_s        = signed'(CALC_W'(offset_a_ff));
   assign off_b_s        = signed'(CALC_W'(offset_b_ff));
   assign off_c_s        = signed'(CALC_W'(offset_c_ff));
   assign twice_first_s  = signed'(CALC_W'({s1_adc_first_ff, 1'b0}));
   assign twice_second_s = signed'(CALC_W'({s1_adc_second_ff, 1'b0}));

   assign ia_direct = sat_current(off_a_s - twice_first_s);
   assign ib_direct = sat_current(off_b_s - twice_second_s);
   assign ib_first  = sat_current(off_b_s - twice_first_s);
   // The third current comes from the second converter less the first current.
   assign ia_from_b = sat_current(twice_second_s - off_c_s - CALC_W'(ib_first));
   assign ib_from_a = sat_current(twice_second_s - off_c_s - CALC_W'(ia_direct));

   assign off_a_twice = {offset_a_ff, 1'b0};
   assign off_b_twice = {offset_b_ff, 1'b0};
   assign off_c_twice = {offset_c_ff, 1'b0};

   // ------------------------------------------------------------------------
   // Command execution
   // ------------------------------------------------------------------------
   always_comb begin
      sample_sector_in  = sample_sector_ff;
      offset_a_in       = offset_a_ff;
      offset_b_in       = offset_b_ff;
      offset_c_in       = offset_c_ff;
      ab_count_in       = ab_count_ff;
      c_count_in        = c_count_ff;
      last_current_a_in = last_current_a_ff;
      last_current_b_in = last_current_b_ff;
      sample_point_in   = '0;
      falling_edge_in   = 1'b0;
      first_phase_in    = PHASE_A;
      second_phase_in   = PHASE_A;
      compare_a_in      = '0;
      compare_b_in      = '0;
      compare_c_in      = '0;
      unique case (s1_command_ff)
         CMD_DUTY: begin
            sample_sector_in = plan.sample_sector;
            sample_point_in  = plan.sample_point;
            falling_edge_in  = plan.falling_edge;
            first_phase_in   = plan.first_phase;
            second_phase_in  = plan.second_phase;
            compare_a_in     = s1_duty_a_ff;
            compare_b_in     = s1_duty_b_ff;
            compare_c_in     = s1_duty_c_ff;
         end
         CMD_RUN: begin
            case (sample_sector_ff) inside
               SEC4, SEC5: begin
                  last_current_a_in = ia_direct;
                  last_current_b_in = ib_direct;
               end
               SEC6, SEC1: begin
                  last_current_b_in = ib_first;
                  last_current_a_in = ia_from_b;
               end
               SEC2, SEC3: begin
                  last_current_a_in = ia_direct;
                  last_current_b_in = ib_from_a;
               end
               default: ;
            endcase
         end
         CMD_CAL_CLEAR: begin
            offset_a_in = '0;
            offset_b_in = '0;
            offset_c_in = '0;
            ab_count_in = '0;
            c_count_in  = '0;
         end
         CMD_CAL_AB: begin
            if (ab_count_ff < AB_LIMIT) begin
               offset_a_in = offset_a_ff + OFFSET_W'(s1_adc_first_ff);
               offset_b_in = offset_b_ff + OFFSET_W'(s1_adc_second_ff);
               ab_count_in = ab_count_ff + AB_COUNT_W'(1);
            end
         end
         CMD_CAL_C: begin
            if (c_count_ff < C_LIMIT) begin
               offset_c_in = offset_c_ff + OFFSET_W'(s1_adc_first_ff)
                           + OFFSET_W'(s1_adc_second_ff);
               c_count_in  = c_count_ff + C_COUNT_W'(1);
            end
         end
         CMD_CAL_DONE: begin
            // Twice the mean sample of each sum.
            offset_a_in  = OFFSET_W'(off_a_twice / SAMPLE_COUNT);
            offset_b_in  = OFFSET_W'(off_b_twice / SAMPLE_COUNT);
            offset_c_in  = OFFSET_W'(off_c_twice / SAMPLE_COUNT);
            compare_a_in = DATA_W'(half_period_ff);
            compare_b_in = DATA_W'(half_period_ff);
            compare_c_in = DATA_W'(half_period_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_sector_ff  <= '0;
         offset_a_ff       <= '0;
         offset_b_ff       <= '0;
         offset_c_ff       <= '0;
         ab_count_ff       <= '0;
         c_count_ff        <= '0;
         last_current_a_ff <= '0;
         last_current_b_ff <= '0;
      end else if (result_load) begin
         sample_sector_ff  <= sample_sector_in;
         offset_a_ff       <= offset_a_in;
         offset_b_ff       <= offset_b_in;
         offset_c_ff       <= offset_c_in;
         ab_count_ff       <= ab_count_in;
         c_count_ff        <= c_count_in;
         last_current_a_ff <= last_current_a_in;
         last_current_b_ff <= last_current_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         sample_point_ff <= sample_point_in;
         falling_edge_ff <= falling_edge_in;
         first_phase_ff  <= first_phase_in;
         second_phase_ff <= second_phase_in;
         compare_a_ff    <= compare_a_in;
         compare_b_ff    <= compare_b_in;
         compare_c_ff    <= compare_c_in;
      end
   end

   // ------------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------------
   // The stored currents only change as a request enters the result register,
   // so they stay steady while a result waits.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_point = sample_point_ff;
   assign rsp_falling_edge = falling_edge_ff;
   assign rsp_first_phase  = first_phase_ff;
   assign rsp_second_phase = second_phase_ff;
   assign rsp_current_a    = last_current_a_ff;
   assign rsp_current_b    = last_current_b_ff;
   assign rsp_current_c    = -last_current_a_ff - last_current_b_ff;
   assign rsp_compare_a    = compare_a_ff;
   assign rsp_compare_b    = compare_b_ff;
   assign rsp_compare_c    = compare_c_ff;

endmodule

[test/tb_three_shunt_current_sensing_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-shunt current sensing unit testbench
// Drives duty updates, sample pairs and calibration runs through the unit
// under several timing settings with random gaps on both channels. A
// scoreboard predicts every output and compares it field by field.
// ----------------------------------------------------------------------------
import tss_pkg::*;

typedef struct packed {
   logic [2:0]        command;
   logic [2:0]        sector;
   logic [DATA_W-1:0] duty_a;
   logic [DATA_W-1:0] duty_b;
   logic [DATA_W-1:0] duty_c;
   logic [DATA_W-1:0] adc_first;
   logic [DATA_W-1:0] adc_second;
} sense_request_type;

typedef struct packed {
   logic [DATA_W-1:0] sample_point;
   logic              falling_edge;
   logic [1:0]        first_phase;
   logic [1:0]        second_phase;
   logic [DATA_W-1:0] current_a;
   logic [DATA_W-1:0] current_b;
   logic [DATA_W-1:0] current_c;
   logic [DATA_W-1:0] compare_a;
   logic [DATA_W-1:0] compare_b;
   logic [DATA_W-1:0] compare_c;
} sense_output_type;

class current_sense_scoreboard;
   localparam int CURRENT_LIMIT = 32767;
   localparam int PRINT_LIMIT   = 100;

   logic [HALF_PERIOD_W-1:0] half_period;
   logic [DATA_W-1:0]        time_after;
   logic [DATA_W-1:0]        time_before;
   logic [2:0]               sample_sector;
   logic [OFFSET_W-1:0]      offset_a;
   logic [OFFSET_W-1:0]      offset_b;
   logic [OFFSET_W-1:0]      offset_c;
   logic [AB_COUNT_W-1:0]    ab_count;
   logic [C_COUNT_W-1:0]     c_count;
   logic signed [DATA_W-1:0] last_current_a;
   logic signed [DATA_W-1:0] last_current_b;
   sense_output_type         sensed_outputs[$];
   int                       errors;

   function new();
      half_period    = HALF_PERIOD_RESET;
      time_after     = '0;
      time_before    = '0;
      sample_sector  = '0;
      offset_a       = '0;
      offset_b       = '0;
      offset_c       = '0;
      ab_count       = '0;
      c_count        = '0;
      last_current_a = '0;
      last_current_b = '0;
      errors         = 0;
   endfunction

   function void write_register(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] data);
      case (index)
         CSR_HALF_PERIOD: half_period = data[HALF_PERIOD_W-1:0];
         CSR_TIME_AFTER:  time_after = data;
         CSR_TIME_BEFORE: time_before = data;
         default: ;
      endcase
   endfunction

   function logic signed [DATA_W-1:0] saturate(int v);
      if (v < -CURRENT_LIMIT) return DATA_W'(-CURRENT_LIMIT);
      if (v > CURRENT_LIMIT) return DATA_W'(CURRENT_LIMIT);
      return v[DATA_W-1:0];
   endfunction

   // Advances the sensing state by one request and returns what it shows.
   function sense_output_type sense_event(sense_request_type r);
      sense_output_type o;
      int unsigned      hp, x, y, room, delta, point, wide;
      int               twice1, twice2, oa, ob, oc, ia, ib;
      logic [1:0]       p1, p2;

      o = '0;
      hp = half_period;
      point = 0;
      x = 0;
      y = 0;
      p1 = PHASE_A;
      p2 = PHASE_B;
      case (r.command)
         CMD_DUTY: begin
            o.compare_a = r.duty_a;
            o.compare_b = r.duty_b;
            o.compare_c = r.duty_c;
            o.first_phase = PHASE_A;
            o.second_phase = PHASE_B;
            if (r.sector >= SEC1 && r.sector <= SEC6) begin
               case (r.sector)
                  SEC1:    begin x = r.duty_a; y = r.duty_b; p1 = PHASE_B; p2 = PHASE_C; end
                  SEC2:    begin x = r.duty_b; y = r.duty_a; p1 = PHASE_A; p2 = PHASE_C; end
                  SEC3:    begin x = r.duty_b; y = r.duty_c; p1 = PHASE_A; p2 = PHASE_C; end
                  SEC4:    begin x = r.duty_c; y = r.duty_b; p1 = PHASE_A; p2 = PHASE_B; end
                  SEC5:    begin x = r.duty_c; y = r.duty_a; p1 = PHASE_A; p2 = PHASE_B; end
                  default: begin x = r.duty_a; y = r.duty_c; p1 = PHASE_B; p2 = PHASE_C; end
               endcase
               room = (hp - x) & 32'hFFFF;
               if (room > time_after) begin
                  // Enough time before the centre: sample A and B there.
                  sample_sector = SEC4;
                  point = (hp - 1) & 32'hFFFF;
               end else begin
                  delta = (x - y) & 32'hFFFF;
                  sample_sector = r.sector;
                  o.first_phase = p1;
                  o.second_phase = p2;
                  if (delta > room * 2) begin
                     point = (x - time_before) & 32'hFFFF;
                  end else begin
                     point = (x + time_after) & 32'hFFFF;
                     if (point >= hp) begin
                        o.falling_edge = 1'b1;
                        point = (2 * hp - point - 1) & 32'hFFFF;
                     end
                  end
               end
            end else begin
               sample_sector = r.sector;
            end
            o.sample_point = point[DATA_W-1:0];
         end
         CMD_RUN: begin
            twice1 = 2 * int'(r.adc_first);
            twice2 = 2 * int'(r.adc_second);
            oa = int'(offset_a);
            ob = int'(offset_b);
            oc = int'(offset_c);
            case (sample_sector) inside
               SEC4, SEC5: begin
                  last_current_a = saturate(oa - twice1);
                  last_current_b = saturate(ob - twice2);
               end
               SEC6, SEC1: begin
                  last_current_b = saturate(ob - twice1);
                  ib = last_current_b;
                  last_current_a = saturate(twice2 - oc - ib);
               end
               SEC2, SEC3: begin
                  last_current_a = saturate(oa - twice1);
                  ia = last_current_a;
                  last_current_b = saturate(twice2 - oc - ia);
               end
               default: ;
            endcase
         end
         CMD_CAL_CLEAR: begin
            offset_a = '0;
            offset_b = '0;
            offset_c = '0;
            ab_count = '0;
            c_count = '0;
         end
         CMD_CAL_AB: begin
            if (ab_count < SAMPLE_COUNT) begin
               offset_a = offset_a + r.adc_first;
               offset_b = offset_b + r.adc_second;
               ab_count = ab_count + 1'b1;
            end
         end
         CMD_CAL_C: begin
            if (c_count < SAMPLE_COUNT / 2) begin
               offset_c = offset_c + r.adc_first + r.adc_second;
               c_count = c_count + 1'b1;
            end
         end
         CMD_CAL_DONE: begin
            wide = offset_a;
            offset_a = OFFSET_W'((wide * 2) / SAMPLE_COUNT);
            wide = offset_b;
            offset_b = OFFSET_W'((wide * 2) / SAMPLE_COUNT);
            wide = offset_c;
            offset_c = OFFSET_W'((wide * 2) / SAMPLE_COUNT);
            o.compare_a = DATA_W'(half_period);
            o.compare_b = DATA_W'(half_period);
            o.compare_c = DATA_W'(half_period);
         end
         default: ;
      endcase
      o.current_a = last_current_a;
      o.current_b = last_current_b;
      o.current_c = DATA_W'(0) - last_current_a - last_current_b;
      return o;
   endfunction

   function void note_request(sense_request_type r);
      sensed_outputs.push_back(sense_event(r));
   endfunction

   function int pending();
      return sensed_outputs.size();
   endfunction

   task report_mismatch(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
   endtask

   task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task check_output(sense_output_type got);
      sense_output_type want;
      if (sensed_outputs.size() == 0) begin
         report_mismatch("output with no request outstanding");
      end else begin
         want = sensed_outputs.pop_front();
         compare_field("sample_point", got.sample_point, want.sample_point);
         compare_field("falling_edge", DATA_W'(got.falling_edge), DATA_W'(want.falling_edge));
         compare_field("first_phase", DATA_W'(got.first_phase), DATA_W'(want.first_phase));
         compare_field("second_phase", DATA_W'(got.second_phase), DATA_W'(want.second_phase));
         compare_field("current_a", got.current_a, want.current_a);
         compare_field("current_b", got.current_b, want.current_b);
         compare_field("current_c", got.current_c, want.current_c);
         compare_field("compare_a", got.compare_a, want.compare_a);
         compare_field("compare_b", got.compare_b, want.compare_b);
         compare_field("compare_c", got.compare_c, want.compare_c);
      end
   endtask
endclass

module tb_three_shunt_current_sensing_unit;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS      = 250;
   localparam int PHASE_COUNT      = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_command = '0;
   logic [2:0]               req_sector = '0;
   logic [DATA_W-1:0]        req_duty_a = '0;
   logic [DATA_W-1:0]        req_duty_b = '0;
   logic [DATA_W-1:0]        req_duty_c = '0;
   logic [DATA_W-1:0]        req_adc_first = '0;
   logic [DATA_W-1:0]        req_adc_second = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [DATA_W-1:0]        rsp_sample_point;
   logic                     rsp_falling_edge;
   logic [1:0]               rsp_first_phase;
   logic [1:0]               rsp_second_phase;
   logic signed [DATA_W-1:0] rsp_current_a;
   logic signed [DATA_W-1:0] rsp_current_b;
   logic signed [DATA_W-1:0] rsp_current_c;
   logic [DATA_W-1:0]        rsp_compare_a;
   logic [DATA_W-1:0]        rsp_compare_b;
   logic [DATA_W-1:0]        rsp_compare_c;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   current_sense_scoreboard board = new();
   bit sender_gaps = 1'b0;
   bit sink_gaps = 1'b0;
   bit long_hold_request = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   three_shunt_current_sensing_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sector       (req_sector),
      .req_duty_a       (req_duty_a),
      .req_duty_b       (req_duty_b),
      .req_duty_c       (req_duty_c),
      .req_adc_first    (req_adc_first),
      .req_adc_second   (req_adc_second),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_point (rsp_sample_point),
      .rsp_falling_edge (rsp_falling_edge),
      .rsp_first_phase  (rsp_first_phase),
      .rsp_second_phase (rsp_second_phase),
      .rsp_current_a    (rsp_current_a),
      .rsp_current_b    (rsp_current_b),
      .rsp_current_c    (rsp_current_c),
      .rsp_compare_a    (rsp_compare_a),
      .rsp_compare_b    (rsp_compare_b),
      .rsp_compare_c    (rsp_compare_c),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int gap_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random stalls, plus one long hold-off counted here on request.
   always @(posedge clock) begin
      if (long_hold_request) begin
         stall_left = LONG_HOLD_CYCLES;
         long_hold_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (sink_gaps && $urandom_range(0, 99) < 20) stall_left = gap_length();
      end
   end

   always @(posedge clock) begin
      sense_output_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.sample_point = rsp_sample_point;
         got.falling_edge = rsp_falling_edge;
         got.first_phase  = rsp_first_phase;
         got.second_phase = rsp_second_phase;
         got.current_a    = rsp_current_a;
         got.current_b    = rsp_current_b;
         got.current_c    = rsp_current_c;
         got.compare_a    = rsp_compare_a;
         got.compare_b    = rsp_compare_b;
         got.compare_c    = rsp_compare_c;
         board.check_output(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("three_shunt_current_sensing_unit verification failed");
            $finish;
         end
      end
   end

   function automatic sense_request_type make_request(logic [2:0] command,
                                                      logic [2:0] sector,
                                                      logic [15:0] a, logic [15:0] b,
                                                      logic [15:0] c, logic [15:0] adc1,
                                                      logic [15:0] adc2);
      sense_request_type r;
      r.command = command;
      r.sector = sector;
      r.duty_a = a;
      r.duty_b = b;
      r.duty_c = c;
      r.adc_first = adc1;
      r.adc_second = adc2;
      return r;
   endfunction

   // Compare counts clustered round the half period so that both sampling
   // rules and both trigger edges are reached.
   function automatic logic [15:0] pick_duty();
      int unsigned hp, span;
      logic [15:0] v;
      hp = board.half_period;
      span = board.time_after + 64;
      if (span > 65535) span = 65535;
      case ($urandom_range(0, 7)) inside
         [0:2]: v = 16'(hp - $urandom_range(0, span));
         3:     v = 16'(hp + $urandom_range(0, 64));
         4: begin
            case ($urandom_range(0, 2))
               0:       v = '0;
               1:       v = '1;
               default: v = 16'(hp);
            endcase
         end
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [15:0] near_value(int unsigned centre, int unsigned spread);
      return 16'(centre + $urandom_range(0, 2 * spread) - spread);
   endfunction

   task automatic drive_request(sense_request_type r);
      req_valid      <= 1'b1;
      req_command    <= r.command;
      req_sector     <= r.sector;
      req_duty_a     <= r.duty_a;
      req_duty_b     <= r.duty_b;
      req_duty_c     <= r.duty_c;
      req_adc_first  <= r.adc_first;
      req_adc_second <= r.adc_second;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      if (sender_gaps && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves csr_valid high so that back-to-back writes need no lowering.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(index, data);
   endtask

   task automatic end_csr_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_calibration();
      int n_ab, n_c;
      logic [15:0] adc1, adc2;
      n_ab = $urandom_range(SAMPLE_COUNT - 2, SAMPLE_COUNT + 2);
      n_c = $urandom_range(SAMPLE_COUNT / 2 - 2, SAMPLE_COUNT / 2 + 2);
      drive_request(make_request(CMD_CAL_CLEAR, 3'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom)));
      repeat (n_ab + n_c) begin
         if ($urandom_range(0, 4) != 0) begin
            adc1 = near_value(32768, 2000);
            adc2 = near_value(32768, 2000);
         end else begin
            adc1 = 16'($urandom);
            adc2 = 16'($urandom);
         end
         drive_request(make_request((n_ab > 0) ? CMD_CAL_AB : CMD_CAL_C, 3'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom),
                                    adc1, adc2));
         if (n_ab > 0) n_ab--;
      end
      drive_request(make_request(CMD_CAL_DONE, 3'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom)));
   endtask

   task automatic send_control_pair();
      logic [2:0] sector;
      logic [15:0] adc1, adc2;
      if ($urandom_range(0, 9) != 0) sector = 3'($urandom_range(1, 6));
      else sector = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
      drive_request(make_request(CMD_DUTY, sector, pick_duty(), pick_duty(), pick_duty(),
                                 16'($urandom), 16'($urandom)));
      if ($urandom_range(0, 99) < 85) begin
         adc1 = near_value(board.offset_a >> 1, 3000);
         adc2 = near_value(board.offset_b >> 1, 3000);
      end else begin
         adc1 = 16'($urandom);
         adc2 = 16'($urandom);
      end
      drive_request(make_request(CMD_RUN, 3'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), adc1, adc2));
   endtask

   task automatic run_traffic(int count);
      int sent, choice;
      sense_request_type r;
      sent = 0;
      while (sent < count) begin
         choice = $urandom_range(0, 99);
         if (choice < 8) begin
            send_calibration();
            sent += SAMPLE_COUNT + SAMPLE_COUNT / 2 + 2;
         end else if (choice < 75) begin
            send_control_pair();
            sent += 2;
         end else begin
            r = make_request(3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
            drive_request(r);
            if (r.command <= CMD_CAL_DONE) sent++;
         end
      end
   endtask

   task automatic apply_settings(int phase);
      int unsigned hp;
      case (phase)
         0: begin
            write_csr(CSR_HALF_PERIOD, 16'd5250);
            write_csr(CSR_TIME_AFTER, 16'd300);
            write_csr(CSR_TIME_BEFORE, 16'd200);
         end
         1: begin
            write_csr(CSR_HALF_PERIOD, 16'h7FFF);
            write_csr(CSR_TIME_AFTER, 16'hFFFF);
            write_csr(CSR_TIME_BEFORE, 16'hFFFF);
         end
         2: begin
            write_csr(CSR_HALF_PERIOD, 16'd1);
            write_csr(CSR_TIME_AFTER, 16'd0);
            write_csr(CSR_TIME_BEFORE, 16'd0);
         end
         3: begin
            hp = $urandom_range(100, 32767);
            write_csr(CSR_HALF_PERIOD, 16'(hp));
            write_csr(CSR_TIME_AFTER, 16'($urandom_range(0, hp)));
            write_csr(CSR_TIME_BEFORE, 16'($urandom_range(0, 3000)));
         end
         4: begin
            // The top bit is dropped, so this leaves a zero half period.
            write_csr(CSR_HALF_PERIOD, 16'h8000);
            write_csr(CSR_TIME_AFTER, 16'($urandom_range(0, 500)));
            write_csr(CSR_TIME_BEFORE, 16'($urandom));
            write_csr(CSR_SPARE, 16'($urandom));
         end
         default: begin
            write_csr(CSR_SPARE, 16'($urandom));
            write_csr(CSR_HALF_PERIOD, 16'($urandom));
            write_csr(CSR_TIME_AFTER, 16'($urandom));
            write_csr(CSR_TIME_BEFORE, 16'($urandom));
         end
      endcase
      end_csr_writes();
      sender_gaps = (phase != 1 && phase != 3);
      sink_gaps = (phase != 1 && phase != 2);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the default timing: a sample before any duty
      // update, unknown sectors and commands, extremes and calibration.
      drive_request(make_request(CMD_RUN, 3'd0, 16'h0, 16'h0, 16'h0, 16'h1234, 16'h8765));
      drive_request(make_request(CMD_DUTY, SEC1, 16'h0, 16'hFFFF, 16'h8000, 16'h0, 16'h0));
      drive_request(make_request(CMD_RUN, 3'd0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF));
      drive_request(make_request(CMD_DUTY, 3'd0, 16'h1111, 16'h2222, 16'h3333, 16'h0, 16'h0));
      drive_request(make_request(CMD_RUN, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0));
      drive_request(make_request(CMD_DUTY, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF));
      drive_request(make_request(3'd6, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      drive_request(make_request(3'd7, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      drive_request(make_request(CMD_CAL_CLEAR, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      drive_request(make_request(CMD_CAL_AB, 3'd0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF));
      drive_request(make_request(CMD_CAL_AB, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      drive_request(make_request(CMD_CAL_C, 3'd0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF));
      drive_request(make_request(CMD_CAL_DONE, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      wait_for_drain();

      // Tight timing so that the per-sector rules and the falling edge apply.
      write_csr(CSR_HALF_PERIOD, 16'd5250);
      write_csr(CSR_TIME_AFTER, 16'd1000);
      write_csr(CSR_TIME_BEFORE, 16'd100);
      end_csr_writes();
      drive_request(make_request(CMD_DUTY, SEC1, 16'd5000, 16'd0, 16'd0, 16'h0, 16'h0));
      drive_request(make_request(CMD_DUTY, SEC2, 16'd5190, 16'd5200, 16'd0, 16'h0, 16'h0));
      drive_request(make_request(CMD_DUTY, SEC3, 16'd0, 16'd4300, 16'd4300, 16'h0, 16'h0));
      drive_request(make_request(CMD_DUTY, SEC4, 16'd0, 16'd4600, 16'd4500, 16'h0, 16'h0));
      drive_request(make_request(CMD_DUTY, SEC5, 16'd0, 16'd0, 16'd5250, 16'h0, 16'h0));
      drive_request(make_request(CMD_RUN, 3'd0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0100));
      drive_request(make_request(CMD_DUTY, SEC6, 16'd5250, 16'd0, 16'd5250, 16'h0, 16'h0));
      drive_request(make_request(CMD_RUN, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'hC000));
      drive_request(make_request(CMD_DUTY, SEC2, 16'd5190, 16'd5200, 16'd0, 16'h0, 16'h0));
      drive_request(make_request(CMD_RUN, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h7FFF));
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         apply_settings(phase);
         if (phase == 2) begin
            run_traffic(PHASE_ITEMS / 2);
            // The receiver holds off while requests keep coming, so the unit
            // fills up and stalls its input; then the sender waits it out.
            long_hold_request = 1'b1;
            repeat (15) send_control_pair();
            wait_for_drain();
            run_traffic(PHASE_ITEMS / 2);
         end else begin
            run_traffic(PHASE_ITEMS);
         end
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("three_shunt_current_sensing_unit verification clean");
      end else begin
         $display("three_shunt_current_sensing_unit verification failed");
      end
      $finish;
   end
endmodule
